// ===== design/mcid_pkg.sv =====
// mcid_pkg: shared widths, register indexes, request codes, lane control and result types for the debouncer
// no dependencies
package mcid_pkg;

  localparam int MASK_W  = 9;
  localparam int DELAY_W = 16;
  localparam int QUERY_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ASSERT_DLY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DLY = 3'd5;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic               accept;
    logic               is_tick;
    logic               started;
    logic [DELAY_W-1:0] assert_delay;
    logic [DELAY_W-1:0] release_delay;
  } lane_ctrl_t;

  typedef struct packed {
    logic [MASK_W-1:0] debounced_mask;
    logic [MASK_W-1:0] raw_mask;
    logic              queried_active;
    logic              queried_raw;
    logic              started;
  } result_t;

endpackage

// ===== design/mcid_in_if.sv =====
// mcid_in_if: request channel of the debouncer (valid/ready and request fields)
// depends on mcid_pkg
interface mcid_in_if
  import mcid_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [MASK_W-1:0]  pin_levels;
  logic [QUERY_W-1:0] query_channel;

  modport source (output valid, req_type, pin_levels, query_channel, input ready);
  modport sink (input valid, req_type, pin_levels, query_channel, output ready);
endinterface

// ===== design/mcid_out_if.sv =====
// mcid_out_if: result channel of the debouncer (valid/ready and result fields)
// depends on mcid_pkg
interface mcid_out_if
  import mcid_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] debounced_mask;
  logic [MASK_W-1:0] raw_mask;
  logic              queried_active;
  logic              queried_raw;
  logic              started;

  modport source (output valid, debounced_mask, raw_mask, queried_active, queried_raw,
                  started, input ready);
  modport sink (input valid, debounced_mask, raw_mask, queried_active, queried_raw,
                started, output ready);
endinterface

// ===== design/mcid_lane.sv =====
// mcid_lane: one channel's debounce state and settle counter
// depends on mcid_pkg
module mcid_lane
  import mcid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  logic       enable,
  input  logic       active_high,
  input  logic       init_from_pin,
  input  logic       preset_active,
  input  logic       pin,
  output logic       debounced
);

  logic               deb_r, deb_nxt;
  logic [DELAY_W-1:0] cnt_r, cnt_nxt;
  logic               now_active;
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] cnt_inc;

  assign now_active = (pin == active_high);
  assign delay      = now_active ? ctrl.assert_delay : ctrl.release_delay;
  assign cnt_inc    = cnt_r + DELAY_W'(1);

  always_comb begin
    deb_nxt = deb_r;
    cnt_nxt = cnt_r;
    if (ctrl.accept && enable) begin
      if (ctrl.is_tick == REQ_START) begin
        deb_nxt = init_from_pin ? now_active : preset_active;
        cnt_nxt = '0;
      end else if (ctrl.started) begin
        if (now_active == deb_r) begin
          cnt_nxt = '0;
        end else if (delay == '0 || cnt_inc >= delay) begin
          deb_nxt = now_active;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      deb_r <= deb_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign debounced = deb_nxt;

  // counter only advances on a counting tick
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != $past(cnt_r))
      |-> $past(ctrl.accept && ctrl.is_tick == REQ_TICK && ctrl.started))
    else $error("settle count changed without a counting tick");

endmodule

// ===== design/mcid_merge.sv =====
// mcid_merge: gathers lane states into the result masks and the queried channel
// depends on mcid_pkg
module mcid_merge
  import mcid_pkg::*;
#(
  parameter int LANES = 9
) (
  input  logic [MASK_W-1:0]  lane_en,
  input  logic [MASK_W-1:0]  lane_deb,
  input  logic [MASK_W-1:0]  pin_levels,
  input  logic [QUERY_W-1:0] query_channel,
  input  logic               started,
  output result_t            result
);

  logic q_ok;

  assign q_ok = (CMP_W'(query_channel) < CMP_W'(LANES)) && lane_en[query_channel];

  always_comb begin
    result.debounced_mask = lane_deb & lane_en;
    result.raw_mask       = pin_levels & lane_en;
    result.queried_active = q_ok ? lane_deb[query_channel] : 1'b0;
    result.queried_raw    = q_ok ? pin_levels[query_channel] : 1'b0;
    result.started        = started;
  end

endmodule

// ===== design/multi_channel_input_debouncer.sv =====
// multi_channel_input_debouncer: top level, config registers, lanes, merge, output buffer
// depends on mcid_pkg, mcid_in_if, mcid_out_if, mcid_lane, mcid_merge
//
// channel  | dir | handshake       | payload
// in_chan  | in  | valid / ready   | req_type, pin_levels, query_channel
// out_chan | out | valid / ready   | debounced_mask, raw_mask, queried_*, started
// cfg_*    | in  | cfg_we          | cfg_index, cfg_wdata
//
// one request per cycle while in_chan.ready is high; each result is registered in the output buffer
// all lanes update in parallel in the accept cycle, result held in a 2-entry buffer
// in_chan.ready drops only while both buffer entries are full
// rst_n synchronous: registers to defaults, lanes cleared, not started
module multi_channel_input_debouncer
  import mcid_pkg::*;
#(
  parameter int CHANNELS = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mcid_in_if.sink               in_chan,
  mcid_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LANES = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  logic [MASK_W-1:0]  enable_r, active_high_r, init_pin_r, preset_r;
  logic [DELAY_W-1:0] assert_dly_r, release_dly_r;
  logic               started_r;

  logic               accept;
  lane_ctrl_t         ctrl;
  logic [MASK_W-1:0]  lane_en;
  logic [MASK_W-1:0]  lane_deb;
  result_t            res_new;

  result_t            main_r, skid_r;
  logic               main_v_r, skid_v_r;
  logic               pop;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= MASK_W'(511);
      active_high_r <= MASK_W'(1);
      init_pin_r    <= MASK_W'(511);
      preset_r      <= '0;
      assert_dly_r  <= DELAY_W'(10);
      release_dly_r <= DELAY_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:      enable_r      <= cfg_wdata[MASK_W-1:0];
        REG_ACTIVE_HIGH: active_high_r <= cfg_wdata[MASK_W-1:0];
        REG_INIT_PIN:    init_pin_r    <= cfg_wdata[MASK_W-1:0];
        REG_PRESET:      preset_r      <= cfg_wdata[MASK_W-1:0];
        REG_ASSERT_DLY:  assert_dly_r  <= cfg_wdata[DELAY_W-1:0];
        REG_RELEASE_DLY: release_dly_r <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !skid_v_r;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (accept && in_chan.req_type == REQ_START) begin
      started_r <= 1'b1;
    end
  end

  always_comb begin
    ctrl.accept        = accept;
    ctrl.is_tick       = in_chan.req_type;
    ctrl.started       = started_r;
    ctrl.assert_delay  = assert_dly_r;
    ctrl.release_delay = release_dly_r;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_en[i] = enable_r[i];
    mcid_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .enable        (enable_r[i]),
      .active_high   (active_high_r[i]),
      .init_from_pin (init_pin_r[i]),
      .preset_active (preset_r[i]),
      .pin           (in_chan.pin_levels[i]),
      .debounced     (lane_deb[i])
    );
  end

  for (genvar i = LANES; i < MASK_W; i++) begin : g_pad
    assign lane_en[i]  = 1'b0;
    assign lane_deb[i] = 1'b0;
  end

  mcid_merge #(.LANES(LANES)) u_merge (
    .lane_en       (lane_en),
    .lane_deb      (lane_deb),
    .pin_levels    (in_chan.pin_levels),
    .query_channel (in_chan.query_channel),
    .started       (started_r || in_chan.req_type == REQ_START),
    .result        (res_new)
  );

  // output buffer: main entry drives the port, skid catches a request under stall
  assign pop = main_v_r && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end else if (accept) begin
        main_r <= res_new;
      end else begin
        main_v_r <= 1'b0;
      end
    end else if (accept) begin
      if (!main_v_r) begin
        main_r   <= res_new;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= res_new;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign out_chan.valid          = main_v_r;
  assign out_chan.debounced_mask = main_r.debounced_mask;
  assign out_chan.raw_mask       = main_r.raw_mask;
  assign out_chan.queried_active = main_r.queried_active;
  assign out_chan.queried_raw    = main_r.queried_raw;
  assign out_chan.started        = main_r.started;

  assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry filled while main entry empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.req_type == REQ_TICK && !started_r) |-> (lane_deb == $past(lane_deb)
      || !$past(rst_n)))
    else $error("tick before start changed debounced state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.req_type == REQ_START) |=> started_r)
    else $error("start request did not set started");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> main_v_r)
    else $error("accepted request left no result");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench: directed and randomized check of multi_channel_input_debouncer
// predicts every result from its own copy of the lane state and config registers
// depends on mcid_pkg, mcid_in_if, mcid_out_if and multi_channel_input_debouncer
module testbench;
  import mcid_pkg::*;

  localparam int NUM_CH = 9;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_REQUESTS = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mcid_in_if  in_chan ();
  mcid_out_if out_chan ();

  multi_channel_input_debouncer #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predicted register file and lane state
  logic [MASK_W-1:0]  en_mask_q;
  logic [MASK_W-1:0]  act_high_q;
  logic [MASK_W-1:0]  init_pin_q;
  logic [MASK_W-1:0]  preset_q;
  logic [DELAY_W-1:0] assert_dly_q;
  logic [DELAY_W-1:0] release_dly_q;
  logic [MASK_W-1:0]  deb_state;
  logic [DELAY_W-1:0] settle_cnt [NUM_CH];
  logic               run_started;

  result_t expected_results [$];

  int error_count;
  int request_count;
  int result_count;
  int start_count;
  int tick_count;
  bit gaps_on;
  bit hold_off_req;
  int hold_off_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic result_t debounce_step(input logic kind, input logic [MASK_W-1:0] pins,
                                            input logic [QUERY_W-1:0] query);
    result_t            res;
    logic               now_active;
    logic [DELAY_W-1:0] limit;
    logic [DELAY_W-1:0] next_cnt;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (en_mask_q[ch]) begin
        now_active = (pins[ch] == act_high_q[ch]);
        if (kind == REQ_START) begin
          deb_state[ch] = init_pin_q[ch] ? now_active : preset_q[ch];
          settle_cnt[ch] = '0;
        end else if (run_started) begin
          if (now_active == deb_state[ch]) begin
            settle_cnt[ch] = '0;
          end else begin
            limit = now_active ? assert_dly_q : release_dly_q;
            next_cnt = settle_cnt[ch] + 1'b1;
            if (limit == '0 || next_cnt >= limit) begin
              deb_state[ch] = now_active;
              settle_cnt[ch] = '0;
            end else begin
              settle_cnt[ch] = next_cnt;
            end
          end
        end
      end
    end
    if (kind == REQ_START) begin
      run_started = 1'b1;
    end
    res.debounced_mask = deb_state & en_mask_q;
    res.raw_mask = pins & en_mask_q;
    res.queried_active = 1'b0;
    res.queried_raw = 1'b0;
    if (query < NUM_CH) begin
      if (en_mask_q[query]) begin
        res.queried_active = deb_state[query];
        res.queried_raw = pins[query];
      end
    end
    res.started = run_started;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [MASK_W-1:0] want_v,
                                      input logic [MASK_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      error_count++;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_mask();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0: v[MASK_W-1:0] = '0;
      1: v[MASK_W-1:0] = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_delay();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 6));
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_request(input logic kind, input logic [MASK_W-1:0] pins,
                              input logic [QUERY_W-1:0] query);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.req_type <= kind;
    in_chan.pin_levels <= pins;
    in_chan.query_channel <= query;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_results.push_back(debounce_step(kind, pins, query));
    request_count++;
    if (kind == REQ_START) begin
      start_count++;
    end else begin
      tick_count++;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    int guard = 0;
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_ENABLE:      en_mask_q = data[MASK_W-1:0];
      REG_ACTIVE_HIGH: act_high_q = data[MASK_W-1:0];
      REG_INIT_PIN:    init_pin_q = data[MASK_W-1:0];
      REG_PRESET:      preset_q = data[MASK_W-1:0];
      REG_ASSERT_DLY:  assert_dly_q = data[DELAY_W-1:0];
      REG_RELEASE_DLY: release_dly_q = data[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_tick_before_start();
    send_request(REQ_TICK, 9'h1FF, 4'd0);
    send_request(REQ_TICK, 9'h000, 4'd15);
  endtask

  task automatic test_start_sampling();
    send_request(REQ_START, 9'h000, 4'd0);
    send_request(REQ_START, 9'h1FF, 4'd8);
    send_request(REQ_START, 9'h155, 4'd9);
    send_request(REQ_TICK, 9'h0AA, 4'd15);
  endtask

  task automatic test_zero_delay();
    drain_results();
    write_reg(REG_ASSERT_DLY, 16'h0000);
    write_reg(REG_RELEASE_DLY, 16'h0000);
    send_request(REQ_START, 9'h000, 4'd1);
    send_request(REQ_TICK, 9'h1FF, 4'd0);
    send_request(REQ_TICK, 9'h000, 4'd8);
  endtask

  task automatic test_lowered_delay();
    drain_results();
    write_reg(REG_ASSERT_DLY, 16'd5);
    write_reg(REG_RELEASE_DLY, 16'd5);
    send_request(REQ_START, 9'h000, 4'd0);
    repeat (3) send_request(REQ_TICK, 9'h1FF, 4'd3);
    // counters sit at three, new delays are already reached
    drain_results();
    write_reg(REG_ASSERT_DLY, 16'd2);
    write_reg(REG_RELEASE_DLY, 16'd1);
    send_request(REQ_TICK, 9'h1FF, 4'd0);
  endtask

  task automatic test_disabled_and_preset();
    drain_results();
    write_reg(REG_ACTIVE_HIGH, 16'hFE5A);
    write_reg(REG_ENABLE, 16'h80F3);
    write_reg(REG_INIT_PIN, 16'h00F0);
    write_reg(REG_PRESET, 16'h7D0A);
    send_request(REQ_START, 9'h1A5, 4'd2);
    send_request(REQ_TICK, 9'h05A, 4'd8);
    send_request(REQ_TICK, 9'h1FF, 4'd4);
  endtask

  task automatic test_max_delay_and_spare_index();
    drain_results();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    write_reg(REG_ASSERT_DLY, 16'hFFFF);
    write_reg(REG_RELEASE_DLY, 16'hFFFF);
    write_reg(REG_ENABLE, 16'h01FF);
    write_reg(REG_INIT_PIN, 16'h0000);
    write_reg(REG_PRESET, 16'h01FF);
    send_request(REQ_START, 9'h000, 4'd7);
    send_request(REQ_TICK, 9'h1FF, 4'd7);
    send_request(REQ_TICK, 9'h000, 4'd12);
  endtask

  task automatic test_backpressure();
    drain_results();
    gaps_on = 1'b0;
    write_reg(REG_INIT_PIN, 16'h01FF);
    write_reg(REG_ASSERT_DLY, 16'd2);
    write_reg(REG_RELEASE_DLY, 16'd3);
    hold_off_req = 1'b1;
    send_request(REQ_START, MASK_W'($urandom), QUERY_W'($urandom));
    repeat (30) send_request(REQ_TICK, MASK_W'($urandom), QUERY_W'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [MASK_W-1:0] level;
    logic [MASK_W-1:0] pins;
    logic              kind;
    int                pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      // one phase runs with no idling on either side
      gaps_on = (phase != 5);
      write_reg(REG_ENABLE, (phase % 2 == 0) ? 16'h01FF : random_mask());
      write_reg(REG_ACTIVE_HIGH, random_mask());
      write_reg(REG_INIT_PIN, random_mask());
      write_reg(REG_PRESET, random_mask());
      write_reg(REG_ASSERT_DLY, random_delay());
      write_reg(REG_RELEASE_DLY, random_delay());
      level = MASK_W'($urandom);
      send_request(REQ_START, level, QUERY_W'($urandom));
      for (int i = 1; i < PHASE_REQUESTS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          level = level ^ (MASK_W'($urandom) & MASK_W'($urandom));
        end
        pins = level;
        if (pick >= 20 && pick < 40) begin
          pins = level ^ MASK_W'($urandom);
        end else if (pick >= 95) begin
          pins = MASK_W'($urandom);
        end
        kind = (pick >= 90 && pick < 95) ? REQ_START : REQ_TICK;
        send_request(kind, pins, QUERY_W'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: debounced_mask %h raw_mask %h started %b",
               out_chan.debounced_mask, out_chan.raw_mask, out_chan.started);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("debounced_mask", want.debounced_mask, out_chan.debounced_mask);
        check_field("raw_mask", want.raw_mask, out_chan.raw_mask);
        check_field("queried_active", MASK_W'(want.queried_active),
                    MASK_W'(out_chan.queried_active));
        check_field("queried_raw", MASK_W'(want.queried_raw), MASK_W'(out_chan.queried_raw));
        check_field("started", MASK_W'(want.started), MASK_W'(out_chan.started));
        result_count++;
      end
    end
  end

  // result receiver
  initial begin
    out_chan.ready = 1'b0;
    hold_off_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= !(gaps_on && $urandom_range(0, 99) < 31);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_START;
    in_chan.pin_levels = '0;
    in_chan.query_channel = '0;
    gaps_on = 1'b1;
    hold_off_req = 1'b0;
    error_count = 0;
    request_count = 0;
    result_count = 0;
    start_count = 0;
    tick_count = 0;
    en_mask_q = 9'h1FF;
    act_high_q = 9'h001;
    init_pin_q = 9'h1FF;
    preset_q = 9'h000;
    assert_dly_q = 16'd10;
    release_dly_q = 16'd10;
    deb_state = '0;
    foreach (settle_cnt[i]) settle_cnt[i] = '0;
    run_started = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_tick_before_start();
    test_start_sampling();
    test_zero_delay();
    test_lowered_delay();
    test_disabled_and_preset();
    test_max_delay_and_spare_index();
    test_backpressure();
    test_random_phases();

    drain_results();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("covered %0d requests (%0d start samples, %0d ticks), %0d results compared",
             request_count, start_count, tick_count, result_count);
    $display("directed corner cases, %0d random config phases and a long output stall",
             RANDOM_PHASES);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
